FILE: rtl/terminal_key_sequence_encoder_assert.svh
// ----------------------------------------------------------------------------
// terminal key sequence encoder assertion macros
// implication checks sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TERMINAL_KEY_SEQUENCE_ENCODER_ASSERT_SVH
`define TERMINAL_KEY_SEQUENCE_ENCODER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define TKSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkse assertion failed");

// next-cycle implication
`define TKSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkse assertion failed");

`else

`define TKSE_ASSERT_IMP(lbl, ante, cons)
`define TKSE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/tkse_pkg.sv
// ----------------------------------------------------------------------------
// tkse_pkg
// types, key codes and xterm sequence tables of the key sequence encoder
// ----------------------------------------------------------------------------
`default_nettype none

package tkse_pkg;

  localparam int TKSE_QUEUE_DEPTH = 2;

  localparam logic [7:0] ESC_BYTE = 8'h1B;

  localparam logic [4:0] KIND_CHAR        = 5'd0;
  localparam logic [4:0] KIND_SHIFT       = 5'd1;
  localparam logic [4:0] KIND_CTRL        = 5'd2;
  localparam logic [4:0] KIND_ALT         = 5'd3;
  localparam logic [4:0] KIND_HIDE        = 5'd4;
  localparam logic [4:0] KIND_NAMED_FIRST = 5'd5;

  typedef struct packed {
    logic [4:0] key_kind;
    logic [7:0] base_char;
    logic [7:0] shifted_char;
  } tkse_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } tkse_out_t;

  typedef logic [2:0] tkse_cnt_t;

  typedef struct packed {
    logic       alt;
    logic       named;
    logic [4:0] idx;
    logic [7:0] char_byte;
    tkse_cnt_t  total;
  } tkse_desc_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } tkse_state_t;

  typedef logic [4:0][7:0] tkse_body_t;

  function automatic tkse_body_t mk_body(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [7:0] b4);
    mk_body = {b4, b3, b2, b1, b0};
  endfunction

  function automatic tkse_cnt_t seq_len(input logic [4:0] idx);
    case (idx)
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4:               seq_len = 3'd1;
      5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10:        seq_len = 3'd3;
      5'd11, 5'd12, 5'd13, 5'd14:                 seq_len = 3'd4;
      5'd15, 5'd16, 5'd17, 5'd18:                 seq_len = 3'd3;
      5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24,
      5'd25, 5'd26:                               seq_len = 3'd5;
      default:                                    seq_len = 3'd1;
    endcase
  endfunction

  function automatic tkse_body_t seq_body(input logic [4:0] idx);
    case (idx)
      5'd0:    seq_body = mk_body(8'h1B, 8'h00, 8'h00, 8'h00, 8'h00);
      5'd1:    seq_body = mk_body(8'h09, 8'h00, 8'h00, 8'h00, 8'h00);
      5'd2:    seq_body = mk_body(8'h0D, 8'h00, 8'h00, 8'h00, 8'h00);
      5'd3:    seq_body = mk_body(8'h7F, 8'h00, 8'h00, 8'h00, 8'h00);
      5'd4:    seq_body = mk_body(8'h20, 8'h00, 8'h00, 8'h00, 8'h00);
      5'd5:    seq_body = mk_body(8'h1B, 8'h5B, 8'h41, 8'h00, 8'h00);
      5'd6:    seq_body = mk_body(8'h1B, 8'h5B, 8'h42, 8'h00, 8'h00);
      5'd7:    seq_body = mk_body(8'h1B, 8'h5B, 8'h43, 8'h00, 8'h00);
      5'd8:    seq_body = mk_body(8'h1B, 8'h5B, 8'h44, 8'h00, 8'h00);
      5'd9:    seq_body = mk_body(8'h1B, 8'h5B, 8'h48, 8'h00, 8'h00);
      5'd10:   seq_body = mk_body(8'h1B, 8'h5B, 8'h46, 8'h00, 8'h00);
      5'd11:   seq_body = mk_body(8'h1B, 8'h5B, 8'h35, 8'h7E, 8'h00);
      5'd12:   seq_body = mk_body(8'h1B, 8'h5B, 8'h36, 8'h7E, 8'h00);
      5'd13:   seq_body = mk_body(8'h1B, 8'h5B, 8'h32, 8'h7E, 8'h00);
      5'd14:   seq_body = mk_body(8'h1B, 8'h5B, 8'h33, 8'h7E, 8'h00);
      5'd15:   seq_body = mk_body(8'h1B, 8'h4F, 8'h50, 8'h00, 8'h00);
      5'd16:   seq_body = mk_body(8'h1B, 8'h4F, 8'h51, 8'h00, 8'h00);
      5'd17:   seq_body = mk_body(8'h1B, 8'h4F, 8'h52, 8'h00, 8'h00);
      5'd18:   seq_body = mk_body(8'h1B, 8'h4F, 8'h53, 8'h00, 8'h00);
      5'd19:   seq_body = mk_body(8'h1B, 8'h5B, 8'h31, 8'h35, 8'h7E);
      5'd20:   seq_body = mk_body(8'h1B, 8'h5B, 8'h31, 8'h37, 8'h7E);
      5'd21:   seq_body = mk_body(8'h1B, 8'h5B, 8'h31, 8'h38, 8'h7E);
      5'd22:   seq_body = mk_body(8'h1B, 8'h5B, 8'h31, 8'h39, 8'h7E);
      5'd23:   seq_body = mk_body(8'h1B, 8'h5B, 8'h32, 8'h30, 8'h7E);
      5'd24:   seq_body = mk_body(8'h1B, 8'h5B, 8'h32, 8'h31, 8'h7E);
      5'd25:   seq_body = mk_body(8'h1B, 8'h5B, 8'h32, 8'h33, 8'h7E);
      5'd26:   seq_body = mk_body(8'h1B, 8'h5B, 8'h32, 8'h34, 8'h7E);
      default: seq_body = mk_body(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/terminal_key_sequence_encoder.sv
// path: key -> descriptor queue -> descriptor register -> output register
// throughput: one byte per cycle unless out_ready stalls the output, 1 to 6
// bytes per emitting key; the byte emitter sets that rate
// keys are taken one per cycle while the descriptor queue has room
// reset: modifier flags clear, queue empties, no byte is pending
// ----------------------------------------------------------------------------
// terminal_key_sequence_encoder
// turns key events into xterm-style terminal byte sequences
// ----------------------------------------------------------------------------
`default_nettype none

`include "terminal_key_sequence_encoder_assert.svh"

module terminal_key_sequence_encoder import tkse_pkg::*; #(
  parameter int QUEUE_DEPTH = TKSE_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tkse_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output tkse_out_t      out_data
);

  logic       q_push;
  logic       q_pop;
  logic       q_ready;
  logic       q_valid;
  logic       named_accept;
  tkse_desc_t push_desc;
  tkse_desc_t head_desc;

  assign named_accept = in_valid && in_ready && (in_data.key_kind >= KIND_NAMED_FIRST);

  tkse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  tkse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .q_ready   (q_ready),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .head_desc (head_desc)
  );

  tkse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head_desc (head_desc),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `TKSE_ASSERT_IMP(a_push_room, q_push, q_ready)
  `TKSE_ASSERT_IMP(a_pop_data, q_pop, q_valid)
  `TKSE_ASSERT_NXT(a_named_queued, named_accept, q_valid)
  `TKSE_ASSERT_NXT(a_seq_continues, out_valid && out_ready && !out_data.last_byte, out_valid)

endmodule

`default_nettype wire

FILE: rtl/tkse_front.sv
// ----------------------------------------------------------------------------
// tkse_front
// takes key requests, keeps the modifier flags and queues one descriptor
// for every key that emits bytes
// ----------------------------------------------------------------------------
`default_nettype none

module tkse_front import tkse_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tkse_in_t   in_data,
  input  wire logic       q_ready,
  output logic            q_push,
  output tkse_desc_t      q_desc
);

  logic       shift_r, shift_nxt;
  logic       ctrl_r, ctrl_nxt;
  logic       alt_r, alt_nxt;
  logic       accept;
  logic       named;
  logic       emits;
  logic [7:0] sel_byte;
  logic [7:0] map_byte;
  logic [4:0] idx;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (shift_r && (in_data.shifted_char != 8'h00)) begin
      sel_byte = in_data.shifted_char;
    end else begin
      sel_byte = in_data.base_char;
    end
    map_byte = sel_byte;
    if (ctrl_r) begin
      if ((sel_byte >= 8'h61) && (sel_byte <= 8'h7A)) begin
        map_byte = sel_byte - 8'h60;
      end else if ((sel_byte >= 8'h40) && (sel_byte <= 8'h5F)) begin
        map_byte = sel_byte - 8'h40;
      end
    end
  end

  assign named  = (in_data.key_kind >= KIND_NAMED_FIRST);
  assign emits  = named || ((in_data.key_kind == KIND_CHAR) && (sel_byte != 8'h00));
  assign idx    = in_data.key_kind - KIND_NAMED_FIRST;
  assign q_push = accept && emits;

  always_comb begin
    q_desc.alt       = alt_r;
    q_desc.named     = named;
    q_desc.idx       = idx;
    q_desc.char_byte = map_byte;
    q_desc.total     = {2'b00, alt_r} + (named ? seq_len(idx) : 3'd1);
  end

  always_comb begin
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    alt_nxt   = alt_r;
    if (accept) begin
      case (in_data.key_kind)
        KIND_SHIFT: shift_nxt = !shift_r;
        KIND_CTRL:  ctrl_nxt  = !ctrl_r;
        KIND_ALT:   alt_nxt   = !alt_r;
        default: begin
          if (emits) begin
            shift_nxt = 1'b0;
            ctrl_nxt  = 1'b0;
            alt_nxt   = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      alt_r   <= 1'b0;
    end else begin
      shift_r <= shift_nxt;
      ctrl_r  <= ctrl_nxt;
      alt_r   <= alt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tkse_queue.sv
// ----------------------------------------------------------------------------
// tkse_queue
// small descriptor queue between the key front end and the byte emitter
// ----------------------------------------------------------------------------
`default_nettype none

module tkse_queue import tkse_pkg::*; #(
  parameter int DEPTH = TKSE_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire tkse_desc_t push_desc,
  output logic            q_ready,
  input  wire logic       pop,
  output logic            q_valid,
  output tkse_desc_t      head_desc
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tkse_desc_t      mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign q_ready   = (count_r != CW'(DEPTH));
  assign q_valid   = (count_r != '0);
  assign head_desc = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tkse_back.sv
// ----------------------------------------------------------------------------
// tkse_back
// walks one descriptor at a time and emits its bytes through an output register
// ----------------------------------------------------------------------------
`default_nettype none

module tkse_back import tkse_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire tkse_desc_t head_desc,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tkse_out_t       out_data
);

  tkse_state_t state_r, state_nxt;
  tkse_desc_t  desc_r;
  tkse_cnt_t   pos_r;
  tkse_cnt_t   body_pos;
  tkse_body_t  body;
  logic        out_valid_r;
  tkse_out_t   out_data_r;
  tkse_out_t   emit_data;
  logic        emit_go;
  logic        last_pos;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign last_pos = (pos_r == (desc_r.total - 3'd1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go && last_pos && !q_valid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    body_pos = pos_r - {2'b00, desc_r.alt};
    body     = seq_body(desc_r.idx);
    case (state_r)
      ST_IDLE: pop = q_valid;
      ST_EMIT: pop = q_valid && emit_go && last_pos;
      default: pop = 1'b0;
    endcase
    if (desc_r.alt && (pos_r == 3'd0)) begin
      emit_data.out_byte = ESC_BYTE;
    end else if (desc_r.named) begin
      emit_data.out_byte = body[body_pos];
    end else begin
      emit_data.out_byte = desc_r.char_byte;
    end
    emit_data.last_byte = last_pos;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      desc_r <= head_desc;
      pos_r  <= 3'd0;
    end else if (emit_go) begin
      pos_r  <= pos_r + 3'd1;
    end
    if (emit_go) begin
      out_data_r <= emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
